FILE: sv/assert_macros.svh
// assertion helpers included by the geometry core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
		else $error(msg);

`endif

FILE: sv/hpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hpr_pkg;

	localparam int RES_W   = 14;
	localparam int PIX_W   = 30;
	localparam int RING_W  = 15;
	localparam int COUNT_W = 16;

	localparam int MAX_RES_LOG2_DEFAULT = 13;

	typedef enum logic [1:0] {
		REGION_NORTH,
		REGION_EQUATOR,
		REGION_SOUTH
	} region_t;

	typedef struct packed {
		logic    vld;
		logic    bad;
		region_t region;
	} tag_t;

endpackage

`default_nettype wire

FILE: sv/hpr_sqrt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hpr_sqrt_cell #(
	parameter int SB = 15
) (
	input  logic                clk,
	input  logic                arst_n,
	input  hpr_pkg::tag_t       tag_i,
	input  logic [SB:0]         rem_i,
	input  logic [SB-1:0]       root_i,
	input  logic [2*SB-1:0]     v_i,
	output hpr_pkg::tag_t       tag_o,
	output logic [SB:0]         rem_o,
	output logic [SB-1:0]       root_o,
	output logic [2*SB-1:0]     v_o
);
	import hpr_pkg::*;

	logic [SB+2:0] t;
	logic [SB+2:0] trial;
	logic          fit;
	logic [SB:0]   rem_n;

	// bring down the next two radicand bits and try root*4+1
	always_comb begin
		t     = {rem_i, v_i[2*SB-1 -: 2]};
		trial = {1'b0, root_i, 2'b01};
		fit   = (t >= trial);
		rem_n = fit ? (SB+1)'(t - trial) : t[SB:0];
	end

	tag_t tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_i;
		end
	end

	logic [SB:0]     rem_q;
	logic [SB-1:0]   root_q;
	logic [2*SB-1:0] v_q;

	always_ff @(posedge clk) begin
		rem_q  <= rem_n;
		root_q <= {root_i[SB-2:0], fit};
		v_q    <= v_i << 2;
	end

	assign tag_o  = tag_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign v_o    = v_q;

endmodule

`default_nettype wire

FILE: sv/hpr_div_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module hpr_div_cell #(
	parameter int DW = 29,
	parameter int QB = 15
) (
	input  logic          clk,
	input  logic [DW-1:0] rem_i,
	input  logic [DW-1:0] ds_i,
	input  logic [QB-1:0] quo_i,
	output logic [DW-1:0] rem_o,
	output logic [DW-1:0] ds_o,
	output logic [QB-1:0] quo_o
);
	import hpr_pkg::*;

	logic fit;

	assign fit = (rem_i >= ds_i);

	logic [DW-1:0] rem_q;
	logic [DW-1:0] ds_q;
	logic [QB-1:0] quo_q;

	// one quotient bit per cell, divisor walks down one place
	always_ff @(posedge clk) begin
		rem_q <= fit ? (rem_i - ds_i) : rem_i;
		ds_q  <= ds_i >> 1;
		quo_q <= {quo_i[QB-2:0], fit};
	end

	assign rem_o = rem_q;
	assign ds_o  = ds_q;
	assign quo_o = quo_q;

endmodule

`default_nettype wire

FILE: sv/healpix_pixel_to_ring_geometry_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake              payload
// command   in   start, busy            pixel_index
// config    in   cfg_valid, cfg_ready   cfg_data (grid_resolution)
// result    out  done                   ring_index, ring_pixel_count,
//                                       pixels_through_ring, ring_first_pixel, bad_pixel
//
// one item per cycle while busy is low; the pipeline is stage 1, the row of
// MAX_RESOLUTION_LOG2 + 2 root/quotient cells and three further stages, four stages in all.
// busy is high after reset and after each config write while the
// n*n multiplier stage and the derived ring constants settle.
// asynchronous active-low reset clears the valid bits of every stage.
// done pulses for one cycle per item; the receiver cannot stall the block.

module healpix_pixel_to_ring_geometry_core #(
	parameter int MAX_RESOLUTION_LOG2 = hpr_pkg::MAX_RES_LOG2_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [hpr_pkg::PIX_W-1:0]   pixel_index,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [hpr_pkg::RES_W-1:0]   cfg_data,
	output logic                        done,
	output logic [hpr_pkg::RING_W-1:0]  ring_index,
	output logic [hpr_pkg::COUNT_W-1:0] ring_pixel_count,
	output logic [hpr_pkg::PIX_W-1:0]   pixels_through_ring,
	output logic [hpr_pkg::PIX_W-1:0]   ring_first_pixel,
	output logic                        bad_pixel
);
	import hpr_pkg::*;
	`include "assert_macros.svh"

	localparam int L   = MAX_RESOLUTION_LOG2;
	localparam int NW  = L + 1;
	localparam int SB  = L + 2;
	localparam int RB  = L + 2;
	localparam int DW  = 2 * L + 3;
	localparam int AW  = (2 * L + 4 > PIX_W + 2) ? 2 * L + 4 : PIX_W + 2;
	localparam int LAT = SB + 4;
	localparam int SQRT_BIAS = 5;

	// configuration
	logic [RES_W-1:0] grid_resolution_q;
	logic [1:0]       settle_q;
	logic             cfg_wr;
	logic             accept;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign busy      = (settle_q != 2'd0);
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_resolution_q <= RES_W'(1);
			settle_q          <= 2'd2;
		end else begin
			if (cfg_wr) begin
				grid_resolution_q <= cfg_data;
				settle_q          <= 2'd2;
			end else if (settle_q != 2'd0) begin
				settle_q <= settle_q - 2'd1;
			end
		end
	end

	// derived constants, recomputed every cycle from the register
	logic [AW-1:0] res_ext;
	logic [NW-1:0] n_cfg;
	logic          res_ok;

	assign res_ext = AW'(grid_resolution_q);
	assign n_cfg   = NW'(grid_resolution_q);
	assign res_ok  = (res_ext != '0) && (res_ext <= (AW'(1) << L));

	logic [2*NW-1:0] nn_q;
	logic [NW-1:0]   n_q;
	logic            res_ok_q;

	always_ff @(posedge clk) begin
		nn_q     <= (2*NW)'(n_cfg) * (2*NW)'(n_cfg);
		n_q      <= n_cfg;
		res_ok_q <= res_ok;
	end

	logic [AW-1:0] nn_w;
	logic [AW-1:0] n_w;
	logic [AW-1:0] npix_q;
	logic [AW-1:0] polar_q;
	logic [AW-1:0] eq_end_q;
	logic [AW-1:0] south_base_q;
	logic [AW-1:0] four_polar_q;
	logic [RB-1:0] nring_q;

	assign nn_w = AW'(nn_q);
	assign n_w  = AW'(n_q);

	always_ff @(posedge clk) begin
		npix_q       <= (nn_w << 3) + (nn_w << 2);
		polar_q      <= (nn_w + n_w) >> 1;
		eq_end_q     <= ((nn_w + n_w) >> 1) + (nn_w << 1) - n_w;
		// south cap mirror: polar - (q - eq_end) - 1 folds to 3n^2 - 1 - q
		south_base_q <= (nn_w << 1) + nn_w - AW'(1);
		four_polar_q <= (nn_w + n_w) << 1;
		nring_q      <= (RB'(n_q) << 2) - RB'(1);
	end

	// stage 1: capture the pixel
	logic             vld_s1;
	logic [PIX_W-1:0] p_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_s1 <= pixel_index;
		end
	end

	logic [AW-1:0] q;
	logic [AW-1:0] qc;
	logic [AW-1:0] qe;
	logic          bad;
	region_t       region;

	always_comb begin
		q   = AW'(p_s1) >> 2;
		bad = !res_ok_q || (AW'(p_s1) >= npix_q);
		if (q < polar_q) begin
			region = REGION_NORTH;
		end else if (q < eq_end_q) begin
			region = REGION_EQUATOR;
		end else begin
			region = REGION_SOUTH;
		end
		qc = (region == REGION_NORTH) ? q : (south_base_q - q);
		qe = q - polar_q;
	end

	// row of root cells and quotient cells
	tag_t            tag_c  [SB+1];
	logic [SB:0]     rem_c  [SB+1];
	logic [SB-1:0]   root_c [SB+1];
	logic [2*SB-1:0] v_c    [SB+1];
	logic [DW-1:0]   drem_c [SB+1];
	logic [DW-1:0]   ds_c   [SB+1];
	logic [SB-1:0]   quo_c  [SB+1];

	assign tag_c[0]  = '{vld: vld_s1, bad: bad, region: region};
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign v_c[0]    = (2*SB)'((qc << 3) + AW'(SQRT_BIAS));
	assign drem_c[0] = DW'(qe);
	assign ds_c[0]   = DW'(n_q) << (SB - 1);
	assign quo_c[0]  = '0;

	for (genvar i = 0; i < SB; i++) begin : g_row
		hpr_sqrt_cell #(.SB(SB)) u_sqrt (
			.clk    (clk),
			.arst_n (arst_n),
			.tag_i  (tag_c[i]),
			.rem_i  (rem_c[i]),
			.root_i (root_c[i]),
			.v_i    (v_c[i]),
			.tag_o  (tag_c[i+1]),
			.rem_o  (rem_c[i+1]),
			.root_o (root_c[i+1]),
			.v_o    (v_c[i+1])
		);

		hpr_div_cell #(.DW(DW), .QB(SB)) u_div (
			.clk   (clk),
			.rem_i (drem_c[i]),
			.ds_i  (ds_c[i]),
			.quo_i (quo_c[i]),
			.rem_o (drem_c[i+1]),
			.ds_o  (ds_c[i+1]),
			.quo_o (quo_c[i+1])
		);
	end

	// stage 2: ring index
	logic [RB-1:0] n_r;
	logic [RB-1:0] cap;
	logic [RB-1:0] r;
	tag_t          tag_e;

	assign n_r   = RB'(n_q);
	assign tag_e = tag_c[SB];
	assign cap   = RB'((root_c[SB] - 1'b1) >> 1);

	always_comb begin
		case (tag_e.region)
			REGION_NORTH:   r = cap;
			REGION_EQUATOR: r = n_r + RB'(quo_c[SB]);
			REGION_SOUTH:   r = nring_q - RB'(1) - cap;
			default:        r = '0;
		endcase
	end

	tag_t          tag_s2;
	logic [RB-1:0] r_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_e;
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= r;
	end

	// stage 3: ring size and the one product
	logic [RB-1:0]   r1;
	logic [RB-1:0]   nr;
	logic [RB-1:0]   m;
	logic [RB-1:0]   mul_a;
	logic [RB-1:0]   mul_b;
	logic [RB+1:0]   count;
	logic [2*RB-1:0] prod;

	always_comb begin
		r1 = r_s2 + RB'(1);
		nr = nring_q - r_s2;
		m  = (nr < r1) ? nr : r1;
		if (n_r < m) begin
			m = n_r;
		end
		count = {m, 2'b00};
		case (tag_s2.region)
			REGION_NORTH: begin
				mul_a = r1;
				mul_b = r_s2 + RB'(2);
			end
			REGION_EQUATOR: begin
				mul_a = n_r;
				mul_b = r1 - n_r;
			end
			REGION_SOUTH: begin
				mul_a = nr - RB'(1);
				mul_b = nr;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		prod = (2*RB)'(mul_a) * (2*RB)'(mul_b);
	end

	tag_t            tag_s3;
	logic [RB-1:0]   r_s3;
	logic [RB+1:0]   count_s3;
	logic [2*RB-1:0] prod_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s3 <= '0;
		end else begin
			tag_s3 <= tag_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3     <= r_s2;
		count_s3 <= count;
		prod_s3  <= prod;
	end

	// stage 4: cumulative count and first pixel, registered outputs
	logic [AW-1:0] pw;
	logic [AW-1:0] through;
	logic [AW-1:0] first;

	always_comb begin
		pw = AW'(prod_s3);
		case (tag_s3.region)
			REGION_NORTH:   through = pw << 1;
			REGION_EQUATOR: through = four_polar_q + (pw << 2);
			REGION_SOUTH:   through = npix_q - (pw << 1);
			default:        through = '0;
		endcase
		first = through - AW'(count_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= tag_s3.vld;
		end
	end

	always_ff @(posedge clk) begin
		bad_pixel <= tag_s3.bad;
		if (tag_s3.bad) begin
			ring_index          <= '0;
			ring_pixel_count    <= '0;
			pixels_through_ring <= '0;
			ring_first_pixel    <= '0;
		end else begin
			ring_index          <= RING_W'(r_s3);
			ring_pixel_count    <= COUNT_W'(count_s3);
			pixels_through_ring <= PIX_W'(through);
			ring_first_pixel    <= PIX_W'(first);
		end
	end

	`ASSERT_IMPL(a_latency, clk, arst_n, accept, ##LAT done, "item result missing at fixed latency")
	`ASSERT_NEXT(a_cfg_settle, clk, arst_n, cfg_wr, busy, "config write not followed by busy")
	`ASSERT_IMPL(a_bad_zero, clk, arst_n, done && bad_pixel, (ring_index == '0) && (ring_pixel_count == '0) && (pixels_through_ring == '0) && (ring_first_pixel == '0), "bad item with nonzero fields")
	`ASSERT_IMPL(a_count_nz, clk, arst_n, done && !bad_pixel, ring_pixel_count != '0, "good item with empty ring")
	`ASSERT_IMPL(a_span, clk, arst_n, done, pixels_through_ring == ring_first_pixel + PIX_W'(ring_pixel_count), "ring span inconsistent")

endmodule

`default_nettype wire
